// ===== rtl/bounds_reason_parser_assert.svh =====
// Assertion macros shared by the bounds reason parser modules.
`ifndef BOUNDS_REASON_PARSER_ASSERT_SVH
`define BOUNDS_REASON_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge outside reset.
`define BRP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bounds_reason_parser: assertion failed");
// Next-cycle implication, checked on every clock edge outside reset.
`define BRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bounds_reason_parser: assertion failed");
`else
`define BRP_ASSERT_IMPLY(label, ante, cons)
`define BRP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/brp_pkg.sv =====
// Types, codes and sizes shared by the bounds reason parser modules.
package brp_pkg;

    localparam int MAX_VARS   = 64;
    localparam int MAX_WORDS  = 65536;
    localparam int VAR_IDX_W  = $clog2(MAX_VARS);
    localparam int CNT_W      = 7;
    localparam int NT_W       = CNT_W + 1;
    localparam int WORD_W     = 32;
    localparam int WL_W       = 17;
    localparam int LIT_W      = 16;
    localparam int CODE_W     = 4;
    localparam int CFG_IDX_W  = 1;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INT_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOAT_COUNT = 1'd1;

    // Parse phases
    localparam logic [1:0] PH_INDEX = 2'd0;
    localparam logic [1:0] PH_COUNT = 2'd1;
    localparam logic [1:0] PH_LITS  = 2'd2;

    // Error codes
    localparam logic [CODE_W-1:0] ERR_NONE      = 4'd0;
    localparam logic [CODE_W-1:0] ERR_INDEX     = 4'd1;
    localparam logic [CODE_W-1:0] ERR_DUP       = 4'd2;
    localparam logic [CODE_W-1:0] ERR_NO_COUNT  = 4'd3;
    localparam logic [CODE_W-1:0] ERR_NEG_COUNT = 4'd4;
    localparam logic [CODE_W-1:0] ERR_TRUNC     = 4'd5;
    localparam logic [CODE_W-1:0] ERR_DEP       = 4'd6;
    localparam logic [CODE_W-1:0] ERR_BOUND     = 4'd7;
    localparam logic [CODE_W-1:0] ERR_MISSING   = 4'd8;

    typedef struct packed {
        logic signed [WORD_W-1:0] word;
        logic [WL_W-1:0]          words_left;
    } item_t;

    typedef struct packed {
        logic [CODE_W-1:0]   error_code;
        logic [MAX_VARS-1:0] int_mask;
        logic [MAX_VARS-1:0] float_mask;
    } result_t;

    // Variable counts from the configuration registers
    typedef struct packed {
        logic [CNT_W-1:0] ni;
        logic [NT_W-1:0]  nt;
    } counts_t;

    // One classified word as queued between front and back
    typedef struct packed {
        logic                 take;
        logic                 last;
        logic                 nt_big;
        logic                 idx_ok;
        logic                 neg;
        logic                 cnt_big;
        logic                 cnt_zero;
        logic [LIT_W-1:0]     cnt;
        logic                 dep_int;
        logic                 dep_float;
        logic                 bound_ok;
        logic [VAR_IDX_W-1:0] idx;
        logic [VAR_IDX_W-1:0] fidx;
    } op_t;

endpackage

// ===== rtl/brp_front.sv =====
// Front end: classifies each incoming word against the variable counts.
module brp_front (
    input  brp_pkg::item_t   item,
    input  brp_pkg::counts_t counts,
    output brp_pkg::op_t     op
);

    logic [brp_pkg::WORD_W-1:0] w;
    logic                       w_neg;
    logic                       w_zero;
    logic [brp_pkg::WL_W-1:0]   wl_clamped;
    logic [brp_pkg::WL_W-1:0]   wl_minus1;
    logic [brp_pkg::WORD_W-1:0] half;
    logic [brp_pkg::WORD_W-1:0] ni_w;
    logic [brp_pkg::WORD_W-1:0] nt_w;

    // Clamp the word count and derive the largest legal literal count
    always_comb
    begin
        if (item.words_left > brp_pkg::WL_W'(brp_pkg::MAX_WORDS))
            wl_clamped = brp_pkg::WL_W'(brp_pkg::MAX_WORDS);
        else
            wl_clamped = item.words_left;
        wl_minus1 = wl_clamped - 1'b1;
        half      = brp_pkg::WORD_W'(wl_minus1[brp_pkg::WL_W-1:1]);
    end

    assign w      = item.word;
    assign w_neg  = w[brp_pkg::WORD_W-1];
    assign w_zero = (w == '0);
    assign ni_w   = brp_pkg::WORD_W'(counts.ni);
    assign nt_w   = brp_pkg::WORD_W'(counts.nt);

    // Classify the word for every phase at once
    always_comb
    begin
        op.take      = (item.words_left != '0);
        op.last      = (item.words_left <= brp_pkg::WL_W'(1));
        op.nt_big    = (counts.nt > brp_pkg::NT_W'(brp_pkg::MAX_VARS));
        op.idx_ok    = !w_neg && !w_zero && (w <= nt_w);
        op.neg       = w_neg;
        op.cnt_big   = !w_neg && (w > half);
        op.cnt_zero  = w_zero;
        op.cnt       = w[brp_pkg::LIT_W-1:0];
        op.dep_int   = !w_neg && !w_zero && (w <= ni_w);
        op.dep_float = !w_neg && (w > ni_w) && (w <= nt_w);
        op.bound_ok  = (w == brp_pkg::WORD_W'(1)) || (w == brp_pkg::WORD_W'(2));
        op.idx       = w[brp_pkg::VAR_IDX_W-1:0] - 1'b1;
        op.fidx      = w[brp_pkg::VAR_IDX_W-1:0] - 1'b1
                       - counts.ni[brp_pkg::VAR_IDX_W-1:0];
    end

endmodule

// ===== rtl/brp_fifo.sv =====
// Short queue of classified words between the front and back ends.
`include "bounds_reason_parser_assert.svh"

module brp_fifo (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  brp_pkg::op_t push_data,
    input  logic         pop,
    output brp_pkg::op_t pop_data,
    output logic         full,
    output logic         empty
);

    brp_pkg::op_t                   mem_reg [brp_pkg::FIFO_DEPTH];
    logic [brp_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [brp_pkg::FIFO_PTR_W-1:0] wr_ptr_next;
    logic [brp_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [brp_pkg::FIFO_PTR_W-1:0] rd_ptr_next;
    logic [brp_pkg::FIFO_CNT_W-1:0] count_reg;
    logic [brp_pkg::FIFO_CNT_W-1:0] count_next;

    assign full     = (count_reg == brp_pkg::FIFO_CNT_W'(brp_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == brp_pkg::FIFO_PTR_W'(brp_pkg::FIFO_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == brp_pkg::FIFO_PTR_W'(brp_pkg::FIFO_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the entry at the tail
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    `BRP_ASSERT_IMPLY(a_fifo_bounded, 1'b1, count_reg <= brp_pkg::FIFO_CNT_W'(brp_pkg::FIFO_DEPTH))
    `BRP_ASSERT_NEXT(a_fifo_push_grows, push && !pop, count_reg == brp_pkg::FIFO_CNT_W'($past(count_reg) + 1'b1))
    `BRP_ASSERT_IMPLY(a_fifo_pop_nonempty, pop, !empty)

endmodule

// ===== rtl/brp_back.sv =====
// Back end: runs the parse state on classified words and holds the result.
`include "bounds_reason_parser_assert.svh"

module brp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  brp_pkg::counts_t  counts,
    input  logic              op_valid,
    input  brp_pkg::op_t      op,
    output logic              op_pop,
    output logic              result_valid,
    input  logic              result_stall,
    output brp_pkg::result_t  result
);

    logic [1:0]                   phase_reg;
    logic [1:0]                   phase_next;
    logic                         side_reg;
    logic                         side_next;
    logic [brp_pkg::LIT_W-1:0]    lits_reg;
    logic [brp_pkg::LIT_W-1:0]    lits_next;
    logic                         half_reg;
    logic                         half_next;
    logic [brp_pkg::MAX_VARS-1:0] expl_reg;
    logic [brp_pkg::MAX_VARS-1:0] expl_next;
    logic [brp_pkg::MAX_VARS-1:0] idep_reg;
    logic [brp_pkg::MAX_VARS-1:0] idep_next;
    logic [brp_pkg::MAX_VARS-1:0] fdep_reg;
    logic [brp_pkg::MAX_VARS-1:0] fdep_next;
    logic [brp_pkg::CODE_W-1:0]   err_reg;
    logic [brp_pkg::CODE_W-1:0]   err_next;
    logic                         rvalid_reg;
    logic                         rvalid_next;
    brp_pkg::result_t             result_reg;
    brp_pkg::result_t             result_next;
    logic [brp_pkg::MAX_VARS-1:0] all_mask;
    logic [brp_pkg::CODE_W-1:0]   code;

    // Take a word whenever the result register is free or being drained
    assign op_pop       = op_valid && (!rvalid_reg || !result_stall);
    assign result_valid = rvalid_reg;
    assign result       = result_reg;

    // Mask of every variable that must be explained
    always_comb
    begin
        if (counts.nt >= brp_pkg::NT_W'(brp_pkg::MAX_VARS))
            all_mask = '1;
        else
            all_mask = (brp_pkg::MAX_VARS'(1) << counts.nt) - 1'b1;
    end

    // Parse one word, then close the reason on its last word
    always_comb
    begin
        phase_next  = phase_reg;
        side_next   = side_reg;
        lits_next   = lits_reg;
        half_next   = half_reg;
        expl_next   = expl_reg;
        idep_next   = idep_reg;
        fdep_next   = fdep_reg;
        err_next    = err_reg;
        rvalid_next = rvalid_reg;
        result_next = result_reg;
        code        = brp_pkg::ERR_NONE;

        if (rvalid_reg && !result_stall)
            rvalid_next = 1'b0;

        if (op_pop)
        begin
            if (op.take && (err_reg == brp_pkg::ERR_NONE))
            begin
                if (op.nt_big)
                    err_next = brp_pkg::ERR_MISSING;
                else
                begin
                    unique case (phase_reg)
                        brp_pkg::PH_INDEX:
                        begin
                            if (!op.idx_ok)
                                err_next = brp_pkg::ERR_INDEX;
                            else if (expl_reg[op.idx])
                                err_next = brp_pkg::ERR_DUP;
                            else
                            begin
                                expl_next[op.idx] = 1'b1;
                                phase_next        = brp_pkg::PH_COUNT;
                                side_next         = 1'b0;
                            end
                        end
                        brp_pkg::PH_COUNT:
                        begin
                            if (op.neg)
                                err_next = brp_pkg::ERR_NEG_COUNT;
                            else if (op.cnt_big)
                                err_next = brp_pkg::ERR_TRUNC;
                            else if (op.cnt_zero)
                            begin
                                phase_next = side_reg ? brp_pkg::PH_INDEX : brp_pkg::PH_COUNT;
                                side_next  = !side_reg;
                            end
                            else
                            begin
                                lits_next  = op.cnt;
                                half_next  = 1'b0;
                                phase_next = brp_pkg::PH_LITS;
                            end
                        end
                        brp_pkg::PH_LITS:
                        begin
                            if (!half_reg)
                            begin
                                if (op.dep_int)
                                begin
                                    idep_next[op.idx] = 1'b1;
                                    half_next         = 1'b1;
                                end
                                else if (op.dep_float)
                                begin
                                    fdep_next[op.fidx] = 1'b1;
                                    half_next          = 1'b1;
                                end
                                else
                                    err_next = brp_pkg::ERR_DEP;
                            end
                            else if (!op.bound_ok)
                                err_next = brp_pkg::ERR_BOUND;
                            else
                            begin
                                half_next = 1'b0;
                                lits_next = lits_reg - 1'b1;
                                if (lits_reg == brp_pkg::LIT_W'(1))
                                begin
                                    phase_next = side_reg ? brp_pkg::PH_INDEX
                                                          : brp_pkg::PH_COUNT;
                                    side_next  = !side_reg;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end

            if (op.last)
            begin
                // Pick the final code
                code = err_next;
                if (code == brp_pkg::ERR_NONE)
                begin
                    if (op.nt_big)
                        code = brp_pkg::ERR_MISSING;
                    else if (phase_next == brp_pkg::PH_COUNT)
                        code = brp_pkg::ERR_NO_COUNT;
                    else if (phase_next == brp_pkg::PH_LITS)
                        code = brp_pkg::ERR_TRUNC;
                    else if (expl_next != all_mask)
                        code = brp_pkg::ERR_MISSING;
                end
                result_next.error_code = code;
                result_next.int_mask   = (code == brp_pkg::ERR_NONE) ? idep_next : '0;
                result_next.float_mask = (code == brp_pkg::ERR_NONE) ? fdep_next : '0;
                rvalid_next            = 1'b1;

                // Drop the parse state for the next reason
                phase_next = brp_pkg::PH_INDEX;
                side_next  = 1'b0;
                lits_next  = '0;
                half_next  = 1'b0;
                expl_next  = '0;
                idep_next  = '0;
                fdep_next  = '0;
                err_next   = brp_pkg::ERR_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= brp_pkg::PH_INDEX;
            side_reg   <= 1'b0;
            lits_reg   <= '0;
            half_reg   <= 1'b0;
            expl_reg   <= '0;
            idep_reg   <= '0;
            fdep_reg   <= '0;
            err_reg    <= brp_pkg::ERR_NONE;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            side_reg   <= side_next;
            lits_reg   <= lits_next;
            half_reg   <= half_next;
            expl_reg   <= expl_next;
            idep_reg   <= idep_next;
            fdep_reg   <= fdep_next;
            err_reg    <= err_next;
            rvalid_reg <= rvalid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    `BRP_ASSERT_IMPLY(a_masks_clear_on_error, rvalid_reg && (result_reg.error_code != brp_pkg::ERR_NONE), (result_reg.int_mask == '0) && (result_reg.float_mask == '0))
    `BRP_ASSERT_IMPLY(a_lits_pending, (phase_reg == brp_pkg::PH_LITS) && (err_reg == brp_pkg::ERR_NONE), lits_reg != '0)
    `BRP_ASSERT_NEXT(a_result_held, rvalid_reg && result_stall, rvalid_reg && (result_reg == $past(result_reg)))

endmodule

// ===== rtl/bounds_reason_parser.sv =====
// Top level of the bounds reason parser: config registers, front, queue, back.
//
// Usage: one reason word enters per transfer on the item channel (item_valid,
// item_stall, item). Each item carries the signed word and the number of
// words left in the reason including this one; 0 ends a reason without a
// word, 1 marks its last word. The block records the first error, collects
// integer and float dependency masks, and on the last item offers one
// transfer on the result channel (result_valid, result_stall, result).
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets
// the integer variable count (index 0) and float variable count (index 1);
// it is always ready; the user must see that it is written only while the
// block is idle, which the block itself does not enforce. Throughput: one
// word per cycle while the result receiver does not stall, limited by the
// single state update in the back end. A last word enters the queue on the
// accepting edge, and the result register loads when the back end takes
// it from the queue, after any words queued ahead of it.
// Reset clears the parse state, the queue, the result valid flag and both
// counts. While the result receiver stalls, the back end holds; the queue
// takes up to two more words and then item_stall rises.
module bounds_reason_parser (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  brp_pkg::item_t                    item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output brp_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [brp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [brp_pkg::CNT_W-1:0]         cfg_data
);

    logic [brp_pkg::CNT_W-1:0] int_count_reg;
    logic [brp_pkg::CNT_W-1:0] float_count_reg;
    brp_pkg::counts_t          counts;
    brp_pkg::op_t              front_op;
    brp_pkg::op_t              back_op;
    logic                      q_full;
    logic                      q_empty;
    logic                      q_push;
    logic                      q_pop;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_count_reg   <= '0;
            float_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                brp_pkg::REG_INT_COUNT:   int_count_reg   <= cfg_data;
                brp_pkg::REG_FLOAT_COUNT: float_count_reg <= cfg_data;
                default:                  int_count_reg   <= int_count_reg;
            endcase
        end
    end

    assign counts.ni = int_count_reg;
    assign counts.nt = brp_pkg::NT_W'(int_count_reg) + brp_pkg::NT_W'(float_count_reg);

    // Accept a word whenever the queue has room
    assign item_stall = q_full;
    assign q_push     = item_valid && !q_full;

    brp_front u_front (
        .item   (item),
        .counts (counts),
        .op     (front_op)
    );

    brp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_op),
        .pop       (q_pop),
        .pop_data  (back_op),
        .full      (q_full),
        .empty     (q_empty)
    );

    brp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .counts       (counts),
        .op_valid     (!q_empty),
        .op           (back_op),
        .op_pop       (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
